// File: src/temperature_to_lcd_digit_stream_defines.svh
// assertion macros for the temperature to lcd digit stream block
// used by the port checker, no other dependencies
`ifndef TEMPERATURE_TO_LCD_DIGIT_STREAM_DEFINES_SVH
`define TEMPERATURE_TO_LCD_DIGIT_STREAM_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define TTL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define TTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/ttl_pkg.sv
// shared types, constants and glyph table of the temperature to lcd digit stream
// no dependencies
package ttl_pkg;

   localparam int MAX_DIGITS  = 3;
   localparam int LIMIT       = 10 ** MAX_DIGITS - 1;
   localparam int MAG_W       = $clog2(LIMIT + 1);
   localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
   localparam int DIG_IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int SAMPLE_W    = 12;
   localparam int COL_W       = 8;
   localparam int DEN_W       = 12;
   localparam int NUM_W       = 21;
   localparam int NUM_MAG_W   = 20;
   localparam int DIV_CNT_W   = $clog2(NUM_MAG_W);
   localparam int GLYPH_BYTES = 9;
   localparam int GLYPH_LEN   = GLYPH_BYTES + 3;
   localparam int BYTE_IDX_W  = $clog2(GLYPH_LEN);

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL30  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL85  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN = 2'd2;

   localparam logic [SAMPLE_W-1:0] CAL30_RESET  = 12'd0;
   localparam logic [SAMPLE_W-1:0] CAL85_RESET  = 12'hFFF;
   localparam logic [COL_W-1:0]    COLUMN_RESET = 8'd123;

   localparam logic [7:0] PAGE_CMD    = 8'hB0;
   localparam logic [7:0] COL_LOW_CMD = 8'h00;
   localparam logic [7:0] COL_HI_CMD  = 8'h10;

   localparam logic [BYTE_IDX_W-1:0] BYTE_PAGE   = 4'd0;
   localparam logic [BYTE_IDX_W-1:0] BYTE_COL_LO = 4'd1;
   localparam logic [BYTE_IDX_W-1:0] BYTE_COL_HI = 4'd2;

   localparam logic [3:0] SYM_PLUS  = 4'd0;
   localparam logic [3:0] SYM_MINUS = 4'd1;
   localparam logic [3:0] SYM_DIGIT = 4'd2;

   localparam logic [7:0] GLYPH_ROM [12][GLYPH_BYTES] = '{
      '{8'h20, 8'h20, 8'h20, 8'h20, 8'hF8, 8'h20, 8'h20, 8'h20, 8'h20},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'hF8, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h78, 8'hFC, 8'hCC, 8'hCC, 8'hCC, 8'hCC, 8'hCC, 8'hFC, 8'h78},
      '{8'h3C, 8'h3C, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'hFC, 8'hFC},
      '{8'hFC, 8'hFC, 8'hC0, 8'hC0, 8'hFC, 8'h0C, 8'h0C, 8'hFC, 8'hFC},
      '{8'hFC, 8'hFC, 8'hC0, 8'hC0, 8'hFC, 8'hC0, 8'hC0, 8'hFC, 8'hFC},
      '{8'hCC, 8'hCC, 8'hCC, 8'hFC, 8'hFC, 8'hC0, 8'hC0, 8'hC0, 8'hC0},
      '{8'hFC, 8'hFC, 8'h0C, 8'h0C, 8'hFC, 8'hFC, 8'hC0, 8'hFC, 8'hFC},
      '{8'hFC, 8'hFC, 8'h0C, 8'hFC, 8'hFC, 8'hCC, 8'hCC, 8'hFC, 8'hFC},
      '{8'hFC, 8'hFC, 8'hC0, 8'hC0, 8'hE0, 8'h70, 8'h30, 8'h30, 8'h30},
      '{8'hFC, 8'hFC, 8'hCC, 8'hCC, 8'hFC, 8'hCC, 8'hCC, 8'hFC, 8'hFC},
      '{8'hFC, 8'hFC, 8'hCC, 8'hCC, 8'hFC, 8'hFC, 8'hC0, 8'hFC, 8'hFC}
   };

   // one converted reading, handed from the front to the back
   typedef struct packed {
      logic                        positive;
      logic [NDIG_W-1:0]           ndig;
      logic [MAX_DIGITS-1:0][3:0]  digits;
   } ttl_entry_type;

endpackage

// File: src/ttl_fifo.sv
// two-entry queue of converted readings between front and back
// depends on ttl_pkg
module ttl_fifo
   import ttl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ttl_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output ttl_entry_type head
);

   ttl_entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/ttl_front.sv
// front part: takes a sample, runs the calibration divide, saturates and
// converts to decimal digits; depends on ttl_pkg
module ttl_front
   import ttl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] cal30,
   input  logic [SAMPLE_W-1:0] cal85,
   output logic                push,
   output ttl_entry_type       push_data,
   input  logic                full
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CALC, ST_DIVIDE, ST_SAT, ST_CONVERT, ST_PUSH
   } state_type;

   state_type                  state_ff, state_in;
   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic [NUM_MAG_W-1:0]       quo_ff, quo_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic                       pos_ff, pos_in;
   logic [DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [MAG_W-1:0]           bin_ff, bin_in;
   logic [MAX_DIGITS-1:0][3:0] bcd_ff, bcd_in;

   logic signed [DEN_W:0]      diff_c, den_c;
   logic signed [NUM_W-1:0]    num_c;
   logic [NUM_W-1:0]           num_abs;
   logic [DEN_W:0]             den_abs;
   logic [DEN_W:0]             trial_c, sub_c;
   logic                       fit_c;
   logic [MAX_DIGITS-1:0][3:0] adj_c;
   logic [NDIG_W-1:0]          ndig_c;

   assign in_ready = (state_ff == ST_IDLE);
   assign push     = (state_ff == ST_PUSH) && !full;

   always_comb begin
      diff_c  = $signed({1'b0, sample_ff}) - $signed({1'b0, cal30});
      den_c   = $signed({1'b0, cal85}) - $signed({1'b0, cal30});
      num_c   = NUM_W'(diff_c) * 21'sd55 + NUM_W'(den_c) * 21'sd30;
      num_abs = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
      den_abs = den_c[DEN_W] ? (DEN_W+1)'(-den_c) : (DEN_W+1)'(den_c);

      trial_c = {rem_ff, quo_ff[NUM_MAG_W-1]};
      sub_c   = trial_c - {1'b0, den_ff};
      fit_c   = (trial_c >= {1'b0, den_ff});

      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj_c[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end

      ndig_c = NDIG_W'(1);
      for (int i = 1; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            ndig_c = NDIG_W'(i + 1);
         end
      end
      push_data.positive = pos_ff;
      push_data.ndig     = ndig_c;
      push_data.digits   = bcd_ff;
   end

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               sample_in = sample;
               state_in  = ST_CALC;
            end
         end
         ST_CALC: begin
            quo_in = num_abs[NUM_MAG_W-1:0];
            rem_in = '0;
            den_in = den_abs[DEN_W-1:0];
            neg_in = num_c[NUM_W-1] ^ den_c[DEN_W];
            cnt_in = '0;
            bcd_in = '0;
            if (den_c == '0) begin
               // equal calibration points read as the positive limit
               bin_in   = MAG_W'(LIMIT);
               pos_in   = 1'b1;
               state_in = ST_CONVERT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = fit_c ? sub_c[DEN_W-1:0] : trial_c[DEN_W-1:0];
            quo_in = {quo_ff[NUM_MAG_W-2:0], fit_c};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(NUM_MAG_W - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            bin_in   = (quo_ff > NUM_MAG_W'(LIMIT)) ? MAG_W'(LIMIT)
                                                    : quo_ff[MAG_W-1:0];
            pos_in   = !neg_ff && (quo_ff != '0);
            cnt_in   = '0;
            state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            // shift-and-add-3 binary to decimal, one bit per cycle
            bcd_in = (MAX_DIGITS*4)'({adj_c, bin_ff[MAG_W-1]});
            bin_in = {bin_ff[MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(MAG_W - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/ttl_back.sv
// back part: walks one queued reading glyph by glyph and drives the byte stream
// depends on ttl_pkg
module ttl_back
   import ttl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  ttl_entry_type    head,
   output logic             pop,
   input  logic [COL_W-1:0] column,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_is_data,
   output logic             out_last
);

   logic [NDIG_W-1:0]     glyph_ff, glyph_in;
   logic [BYTE_IDX_W-1:0] byte_ff,  byte_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            data_ff,  data_in;
   logic                  is_data_ff, is_data_in;
   logic                  last_ff,  last_in;

   logic                  load_c;
   logic                  end_c;
   logic [NDIG_W-1:0]     page_c;
   logic [7:0]            page8_c;
   logic [NDIG_W-1:0]     dig_pos_c;
   logic [3:0]            sym_c;
   logic [BYTE_IDX_W-1:0] rom_idx_c;
   logic [7:0]            byte_c;

   assign out_valid   = valid_ff;
   assign out_byte    = data_ff;
   assign out_is_data = is_data_ff;
   assign out_last    = last_ff;
   assign load_c      = !empty && (!valid_ff || out_ready);
   assign end_c       = (glyph_ff == head.ndig) &&
                        (byte_ff == BYTE_IDX_W'(GLYPH_LEN - 1));
   assign pop         = load_c && end_c;

   always_comb begin
      page_c    = (glyph_ff == '0) ? head.ndig : head.ndig - glyph_ff;
      page8_c   = 8'(page_c);
      if (page8_c > 8'd7) begin
         page8_c = 8'd7;
      end
      dig_pos_c = head.ndig - glyph_ff;
      if (glyph_ff == '0) begin
         sym_c = head.positive ? SYM_PLUS : SYM_MINUS;
      end else begin
         sym_c = head.digits[dig_pos_c[DIG_IDX_W-1:0]] + SYM_DIGIT;
      end
      rom_idx_c = byte_ff - BYTE_IDX_W'(3);
      case (byte_ff)
         BYTE_PAGE:   byte_c = PAGE_CMD + (8'd7 - page8_c);
         BYTE_COL_LO: byte_c = COL_LOW_CMD + {4'd0, column[3:0]};
         BYTE_COL_HI: byte_c = COL_HI_CMD + {4'd0, column[7:4]};
         default:     byte_c = GLYPH_ROM[sym_c][rom_idx_c];
      endcase
   end

   always_comb begin
      glyph_in   = glyph_ff;
      byte_in    = byte_ff;
      valid_in   = valid_ff && !out_ready;
      data_in    = data_ff;
      is_data_in = is_data_ff;
      last_in    = last_ff;
      if (load_c) begin
         valid_in   = 1'b1;
         data_in    = byte_c;
         is_data_in = (byte_ff > BYTE_COL_HI);
         last_in    = end_c;
         if (end_c) begin
            glyph_in = '0;
            byte_in  = '0;
         end else if (byte_ff == BYTE_IDX_W'(GLYPH_LEN - 1)) begin
            glyph_in = glyph_ff + NDIG_W'(1);
            byte_in  = '0;
         end else begin
            byte_in  = byte_ff + BYTE_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff    <= data_in;
      is_data_ff <= is_data_in;
      last_ff    <= last_in;
      if (reset) begin
         glyph_ff <= '0;
         byte_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         glyph_ff <= glyph_in;
         byte_ff  <= byte_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: src/temperature_to_lcd_digit_stream.sv
// top level: sensor sample in, lcd command and glyph byte stream out
// depends on ttl_pkg, ttl_front, ttl_fifo, ttl_back
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata[11:0] sample
//   rsp      out  rsp_tvalid/tready     tdata[7:0] lcd_byte, tuser[0] is_data, tlast last
//   csr      in   csr_we                csr_index, csr_wdata
//
// in the front a sample passes load, setup, 20 divide steps, saturate,
// 10 decimal shift steps and queue write; the divide loop has the most steps
// the back sends 12 bytes per glyph, one per cycle unless stalled, 24 to 48 per sample
// reset is synchronous, active high, and clears queue, back counters and handshakes
// a low rsp_tready holds the output byte; the two-entry queue lets the front
// take and convert further samples meanwhile
module temperature_to_lcd_digit_stream
   import ttl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [11:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] lcd_byte
   output logic [0:0]            rsp_tuser,   // [0] is_data
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SAMPLE_W-1:0] cal30_ff, cal30_in;
   logic [SAMPLE_W-1:0] cal85_ff, cal85_in;
   logic [COL_W-1:0]    column_ff, column_in;

   logic          push, full, pop, empty;
   ttl_entry_type push_data, head;

   always_comb begin
      cal30_in  = cal30_ff;
      cal85_in  = cal85_ff;
      column_in = column_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAL30:  cal30_in  = csr_wdata[SAMPLE_W-1:0];
            CSR_CAL85:  cal85_in  = csr_wdata[SAMPLE_W-1:0];
            CSR_COLUMN: column_in = csr_wdata[COL_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal30_ff  <= CAL30_RESET;
         cal85_ff  <= CAL85_RESET;
         column_ff <= COLUMN_RESET;
      end else begin
         cal30_ff  <= cal30_in;
         cal85_ff  <= cal85_in;
         column_ff <= column_in;
      end
   end

   ttl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sample    (req_tdata[SAMPLE_W-1:0]),
      .cal30     (cal30_ff),
      .cal85     (cal85_ff),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   ttl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   ttl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .head        (head),
      .pop         (pop),
      .column      (column_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_is_data (rsp_tuser[0]),
      .out_last    (rsp_tlast)
   );

endmodule

// File: src/ttl_checker.sv
// port checker for the temperature to lcd digit stream, bound to the top level
// depends on temperature_to_lcd_digit_stream_defines.svh
`include "temperature_to_lcd_digit_stream_defines.svh"

module ttl_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [7:0]            rsp_tdata,
   input logic [0:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled byte holds
   `TTL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp byte changed while stalled")

   // one sample at a time in the front
   `TTL_ASSERT_NEXT(a_req_busy, req_tvalid && req_tready, !req_tready, "front took a second sample without working on the first")

   // command bytes are page or column commands only
   `TTL_ASSERT_NOW(a_cmd_code, rsp_tvalid && !rsp_tuser[0], rsp_tdata[7:4] == 4'hB || rsp_tdata[7:4] == 4'h0 || rsp_tdata[7:4] == 4'h1, "bad command byte")

   // the run of a sample ends on a pixel byte
   `TTL_ASSERT_NOW(a_last_data, rsp_tvalid && rsp_tlast, rsp_tuser[0], "last flag on a command byte")

endmodule

bind temperature_to_lcd_digit_stream ttl_checker u_ttl_checker (.*);
